### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and held off by arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SFP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the following clock edge.
`define SFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sfp32_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp32_pkg
// Types, constants and round functions of the small fast generator.
// ----------------------------------------------------------------------------
package sfp32_pkg;

	localparam int WORD_W = 32;
	localparam int WARM_W = 7;
	localparam int WARMUP_ROUNDS_DEF = 64;

	localparam logic [WORD_W-1:0] WORD_A_INIT     = 32'hf1ea5eed;
	localparam logic [WORD_W-1:0] WORD_RESET_FILL = 32'hb4c0ffee;

	localparam logic CMD_NEXT   = 1'b0;
	localparam logic CMD_RESEED = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
		logic [WORD_W-1:0] d;
	} gen_state_t;

	// Request from the stream front end to the generator core.
	typedef struct packed {
		logic              run;
		logic              reseed;
		logic [WORD_W-1:0] seed;
	} core_req_t;

	// Status of the generator core.
	typedef struct packed {
		logic              busy;
		logic [WORD_W-1:0] word;
	} core_stat_t;

	function automatic logic [WORD_W-1:0] round_out(input gen_state_t s);
		return s.a - {s.b[4:0], s.b[31:5]};
	endfunction

	function automatic gen_state_t round_next(input gen_state_t s);
		gen_state_t        n;
		logic [WORD_W-1:0] e;
		e   = round_out(s);
		n.a = s.b ^ {s.c[14:0], s.c[31:15]};
		n.b = s.c + s.d;
		n.c = s.d + e;
		n.d = n.a + e;
		return n;
	endfunction

endpackage

### hdl/sfp32_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp32_core
// Generator state words, one round per cycle during warm-up or on a run request, and the warm-up counter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfp32_core
	import sfp32_pkg::*;
#(
	parameter int WARMUP_ROUNDS = WARMUP_ROUNDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  core_req_t  req,
	output core_stat_t stat
);

	localparam logic [WARM_W-1:0] WARM_LOAD = WARM_W'(WARMUP_ROUNDS);

	gen_state_t        gen_q;
	logic [WARM_W-1:0] warm_q;
	logic              busy;

	assign busy      = (warm_q != '0);
	assign stat.busy = busy;
	assign stat.word = round_out(gen_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q.a <= WORD_A_INIT;
			gen_q.b <= WORD_RESET_FILL;
			gen_q.c <= WORD_RESET_FILL;
			gen_q.d <= WORD_RESET_FILL;
			warm_q  <= '0;
		end else if (req.reseed) begin
			gen_q.a <= WORD_A_INIT;
			gen_q.b <= req.seed;
			gen_q.c <= req.seed;
			gen_q.d <= req.seed;
			warm_q  <= WARM_LOAD;
		end else if (busy) begin
			// Warm-up rounds advance the state and drop the output.
			gen_q  <= round_next(gen_q);
			warm_q <= warm_q - 1'b1;
		end else if (req.run) begin
			gen_q <= round_next(gen_q);
		end
	end

	`SFP_ASSERT(a_no_req_busy, !(busy && (req.run || req.reseed)),
		"request issued during warm-up")
	`SFP_ASSERT_NEXT(a_reseed_load, req.reseed, warm_q == WARM_LOAD,
		"warm-up counter not loaded on reseed")
	`SFP_ASSERT_NEXT(a_warm_dec, busy, warm_q == $past(warm_q) - 1'b1,
		"warm-up counter did not step down")

endmodule

### hdl/small_fast_prng_32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_fast_prng_32
// Small fast pseudo-random generator with stream input and output.
// ----------------------------------------------------------------------------
// Each input word carries a command in s_tuser and a seed in s_tdata. A next
// command returns one 32-bit random word on the master side; a reseed command
// loads the state from the seed and returns nothing.
// A word is latched into an input register, then one round of the generator
// runs between that register and the output register, so a next command
// shows up on m_tdata once the output register takes it from the input register.
// Next commands are taken one per cycle while the output side keeps up.
// A reseed loads the state and then runs WARMUP_ROUNDS (modulo 128) rounds of
// warm-up, one round per cycle through the same round logic; s_tready stays low
// during the warm-up.
// Reset loads the fixed initial state and runs no warm-up.
// When the receiver stalls, the output register holds its word and the input
// register absorbs one more word before s_tready falls.
// ----------------------------------------------------------------------------

module small_fast_prng_32
	import sfp32_pkg::*;
#(
	parameter int WARMUP_ROUNDS = WARMUP_ROUNDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [WORD_W-1:0] s_tdata,   // seed
	input  logic              s_tuser,   // command
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [WORD_W-1:0] m_tdata    // random_word
);

	logic              valid_s1;
	logic              cmd_s1;
	logic [WORD_W-1:0] seed_s1;
	logic              m_valid_q;
	logic [WORD_W-1:0] word_q;
	logic              out_free;
	logic              consume;
	core_req_t         req;
	core_stat_t        stat;

	assign out_free = !m_valid_q || m_tready;
	assign consume  = valid_s1 && !stat.busy && ((cmd_s1 == CMD_RESEED) || out_free);
	assign s_tready = !stat.busy && (!valid_s1 || consume);

	assign req.run    = consume && (cmd_s1 == CMD_NEXT);
	assign req.reseed = consume && (cmd_s1 == CMD_RESEED);
	assign req.seed   = seed_s1;

	sfp32_core #(
		.WARMUP_ROUNDS(WARMUP_ROUNDS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.stat  (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			seed_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= req.run;
		end
	end

	always_ff @(posedge clk) begin
		if (req.run) begin
			word_q <= stat.word;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = word_q;

endmodule

### tb/small_fast_prng_32_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_fast_prng_32_test
// Self-checking bench for the small fast pseudo-random generator.
// ----------------------------------------------------------------------------
// Next and reseed commands are streamed into the block. A local copy of the
// generator state predicts every random word, including the warm-up rounds
// after a reseed. Each word on the output stream is compared with the oldest
// prediction. The run covers the reset state, seed extremes, repeated seeds,
// a long output stall, a drain pause and random traffic under three idling
// patterns.
// ----------------------------------------------------------------------------

module small_fast_prng_32_test;
	import sfp32_pkg::*;

	localparam int WARMUP_ROUNDS = WARMUP_ROUNDS_DEF;
	// The warm-up counter is seven bits wide.
	localparam int WARMUP_LEN    = WARMUP_ROUNDS % 128;
	localparam int STALL_LIMIT   = 2000;
	localparam int PRINT_LIMIT   = 40;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [WORD_W-1:0] s_tdata  = '0;       // seed
	logic              s_tuser  = CMD_NEXT; // command
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [WORD_W-1:0] m_tdata;             // random_word

	int send_idle_pct     = 0;
	int recv_idle_pct     = 0;
	int long_stall_cycles = 0;
	int idle_cycles       = 0;
	int error_count       = 0;

	gen_state_t        gen;
	logic [WORD_W-1:0] expected_words[$];
	logic [WORD_W-1:0] last_seed = '0;
	logic [WORD_W-1:0] word_due;

	small_fast_prng_32 #(
		.WARMUP_ROUNDS(WARMUP_ROUNDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int unsigned s);
		return (v << s) | (v >> (WORD_W - s));
	endfunction

	function automatic logic [WORD_W-1:0] advance_generator();
		logic [WORD_W-1:0] e;
		e     = gen.a - rotl(gen.b, 27);
		gen.a = gen.b ^ rotl(gen.c, 17);
		gen.b = gen.c + gen.d;
		gen.c = gen.d + e;
		gen.d = gen.a + e;
		return e;
	endfunction

	function automatic void predict_word(input logic cmd, input logic [WORD_W-1:0] seed);
		if (cmd == CMD_RESEED) begin
			gen.a = WORD_A_INIT;
			gen.b = seed;
			gen.c = seed;
			gen.d = seed;
			repeat (WARMUP_LEN) void'(advance_generator());
		end else begin
			expected_words.push_back(advance_generator());
		end
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("%0t ns: %s", $time, msg);
	endtask

	// Offers one word, with a random gap first, and returns once it is taken.
	task automatic send_word(input logic cmd, input logic [WORD_W-1:0] seed);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= seed;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_word(cmd, seed);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_words.size() != 0);
	endtask

	// Random stall pattern, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (long_stall_cycles != 0) begin
			m_tready          <= 1'b0;
			long_stall_cycles <= long_stall_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %08h", m_tdata));
			end else begin
				word_due = expected_words.pop_front();
				if (m_tdata !== word_due)
					report_mismatch($sformatf("random_word %08h, expected %08h",
						m_tdata, word_due));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// Words straight out of reset, with the ignored seed field toggled.
	task automatic test_reset_state();
		send_word(CMD_NEXT, '0);
		send_word(CMD_NEXT, '1);
		send_word(CMD_NEXT, 32'h0000ffff);
		send_word(CMD_NEXT, 32'hffff0000);
	endtask

	task automatic test_reseed_extremes();
		logic [WORD_W-1:0] seeds[4];
		seeds = '{32'h00000000, 32'hffffffff, 32'haaaaaaaa, 32'h55555555};
		foreach (seeds[i]) begin
			send_word(CMD_RESEED, seeds[i]);
			send_word(CMD_NEXT, $urandom);
			send_word(CMD_NEXT, $urandom);
		end
	endtask

	// The same seed twice must restart the same sequence.
	task automatic test_reseed_repeat();
		repeat (2) begin
			send_word(CMD_RESEED, 32'h12345678);
			repeat (3) send_word(CMD_NEXT, $urandom);
		end
		last_seed = 32'h12345678;
	endtask

	task automatic test_output_backpressure();
		send_idle_pct     = 0;
		recv_idle_pct     = 0;
		long_stall_cycles = 300;
		repeat (24) send_word(CMD_NEXT, $urandom);
		send_word(CMD_RESEED, $urandom);
		repeat (8) send_word(CMD_NEXT, $urandom);
	endtask

	task automatic test_pause_for_drain();
		send_idle_pct = 0;
		recv_idle_pct = 50;
		repeat (3) begin
			repeat (6) send_word(CMD_NEXT, $urandom);
			wait_for_drain();
			send_word(CMD_RESEED, $urandom);
			send_word(CMD_NEXT, $urandom);
		end
	endtask

	task automatic test_random_traffic(input int count, input int tx_idle, input int rx_idle);
		logic [WORD_W-1:0] seed;
		send_idle_pct = tx_idle;
		recv_idle_pct = rx_idle;
		repeat (count) begin
			if ($urandom_range(15) == 0) begin
				case ($urandom_range(3))
					0: begin
						seed = last_seed;
					end
					1: begin
						seed = $urandom_range(1) ? '1 : '0;
					end
					default: begin
						seed = $urandom;
					end
				endcase
				last_seed = seed;
				send_word(CMD_RESEED, seed);
			end else begin
				send_word(CMD_NEXT, $urandom);
			end
		end
	endtask

	initial begin
		gen = '{WORD_A_INIT, WORD_RESET_FILL, WORD_RESET_FILL, WORD_RESET_FILL};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_reseed_extremes();
		test_reseed_repeat();
		test_output_backpressure();
		test_pause_for_drain();
		test_random_traffic(500, 21, 88);
		test_random_traffic(500, 88, 21);
		test_random_traffic(500, 0, 0);

		// A final reseed may still be warming up with nothing left to deliver.
		wait_for_drain();
		repeat (WARMUP_LEN + 8) @(posedge clk);
		if (expected_words.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### small_fast_prng_32.f
+incdir+hdl
hdl/sfp32_pkg.sv
hdl/sfp32_core.sv
hdl/small_fast_prng_32.sv
tb/small_fast_prng_32_test.sv
